### design/rmv_pkg.sv
package rmv_pkg;

	typedef struct packed {
		logic        command;
		logic [31:0] sample;
	} rmv_in_t;

	typedef struct packed {
		logic [31:0] sample_count;
		logic [31:0] running_mean;
		logic [47:0] sample_variance;
		logic [31:0] std_deviation;
		logic        sample_ignored;
	} rmv_out_t;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_DIV1,
		ST_MEAN,
		ST_MUL,
		ST_ACC,
		ST_VSETUP,
		ST_DIV2,
		ST_SQRT,
		ST_OUT
	} rmv_state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic skip;
		logic delta;
		logic div_start;
		logic mean;
		logic mul_step;
		logic acc;
		logic vsetup;
		logic sqrt_start;
		logic sqrt_step;
		logic out_load;
	} rmv_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic sqrt_done;
		logic cnt_big;
	} rmv_sts_t;

endpackage

### design/rmv_ctrl.sv
module rmv_ctrl
	import rmv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic       in_clear,
	input  logic       in_sat,
	input  logic       out_free,
	input  rmv_sts_t   sts,
	output rmv_cmd_t   cmd,
	output logic       busy
);

	rmv_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) begin
				if (in_clear || in_sat) state_d = ST_VSETUP;
				else state_d = ST_DELTA;
			end
			ST_DELTA:  state_d = ST_DIV1;
			ST_DIV1:   if (sts.div_done) state_d = ST_MEAN;
			ST_MEAN:   state_d = ST_MUL;
			ST_MUL:    if (sts.mul_done) state_d = ST_ACC;
			ST_ACC:    state_d = ST_VSETUP;
			ST_VSETUP: state_d = sts.cnt_big ? ST_DIV2 : ST_OUT;
			ST_DIV2:   if (sts.div_done) state_d = ST_SQRT;
			ST_SQRT:   if (sts.sqrt_done) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = in_fire;
				cmd.clear = in_fire && in_clear;
				cmd.skip  = in_fire && !in_clear && in_sat;
			end
			ST_DELTA:  begin
				cmd.delta = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_MEAN:   cmd.mean = 1'b1;
			ST_MUL:    cmd.mul_step = 1'b1;
			ST_ACC:    cmd.acc = 1'b1;
			ST_VSETUP: begin
				cmd.vsetup = 1'b1;
				cmd.div_start = sts.cnt_big;
			end
			ST_DIV2:   cmd.sqrt_start = sts.div_done;
			ST_SQRT:   cmd.sqrt_step = 1'b1;
			ST_OUT:    cmd.out_load = out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

### design/rmv_dp.sv
module rmv_dp
	import rmv_pkg::*;
(
	input  logic     clk,
	input  rmv_in_t  in_item,
	input  rmv_cmd_t cmd,
	input  logic     arst_n,
	output rmv_sts_t sts,
	output logic     sat,
	output rmv_out_t res
);

	logic [31:0] count_q;
	logic [47:0] mean_q;
	logic [63:0] sum_q;
	logic [31:0] sample_q;
	logic        ign_q;
	logic        dneg_q;
	logic [47:0] dmag_q;

	// Shared restoring divider: 64-bit dividend, 32-bit divisor, one bit a cycle.
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  div_cnt_q;
	logic        div_busy_q;
	logic [33:0] rem_sh;
	logic [33:0] rem_sub;

	// Shift-add multiplier over 48 bits of the second operand, four bits a cycle.
	logic [99:0] prod_q;
	logic [47:0] mplr_q;
	logic [3:0]  mul_cnt_q;

	// Square root, one result bit a cycle.
	logic [63:0] rad_q;
	logic [33:0] root_q;
	logic [65:0] srem_q;
	logic [5:0]  sq_cnt_q;
	logic [65:0] trial;
	logic [65:0] srem_sh;

	logic [47:0] var_q;
	logic [32:0] count_inc;
	logic [48:0] xw;
	logic [48:0] mean_new;
	logic [48:0] d2;
	logic [64:0] acc_sum;
	logic [51:0] pp;

	assign sat = (count_q == 32'hFFFF_FFFF);
	assign sts.cnt_big = (count_q > 32'd1);
	assign sts.div_done = div_busy_q && (div_cnt_q == 7'd0);
	assign sts.mul_done = (mul_cnt_q == 4'd12);
	assign sts.sqrt_done = (sq_cnt_q == 6'd0);

	assign count_inc = {1'b0, count_q} + 33'd1;
	assign xw = {{1{sample_q[31]}}, sample_q, 16'd0};
	assign mean_new = dneg_q ? ({mean_q[47], mean_q} - {1'b0, quo_q[47:0]})
	                         : ({mean_q[47], mean_q} + {1'b0, quo_q[47:0]});
	assign d2 = xw - mean_new;
	assign rem_sh = {rem_q, quo_q[63]};
	assign rem_sub = rem_sh - {2'b0, dvs_q};
	assign pp = {4'd0, dmag_q} * {48'd0, mplr_q[3:0]};
	assign acc_sum = {1'b0, sum_q} + ((prod_q[99:96] != 4'd0) ? {1'b0, 64'hFFFF_FFFF_FFFF_FFFF}
	                                                          : {1'b0, prod_q[95:32]});
	assign srem_sh = {srem_q[63:0], rad_q[63:62]};
	assign trial = {30'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q <= '0;
			sum_q <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
			mul_cnt_q <= '0;
			sq_cnt_q <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				mean_q <= '0;
				sum_q <= '0;
			end
			if (cmd.delta) count_q <= count_inc[31:0];
			if (cmd.mean) mean_q <= mean_new[47:0];
			if (cmd.acc) sum_q <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];

			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= 7'd64;
			end else if (div_busy_q && div_cnt_q != 7'd0) begin
				div_cnt_q <= div_cnt_q - 7'd1;
			end else begin
				div_busy_q <= 1'b0;
			end

			if (cmd.mean) mul_cnt_q <= '0;
			else if (cmd.mul_step && mul_cnt_q != 4'd12) mul_cnt_q <= mul_cnt_q + 4'd1;

			if (cmd.sqrt_start) sq_cnt_q <= 6'd32;
			else if (cmd.sqrt_step && sq_cnt_q != 6'd0) sq_cnt_q <= sq_cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_item.sample;
			ign_q <= cmd.skip;
		end
		if (cmd.delta) begin
			dneg_q <= (xw - {mean_q[47], mean_q}) >> 48 != 49'd0;
			dmag_q <= (xw - {mean_q[47], mean_q}) >> 48 != 49'd0
			          ? 48'(({mean_q[47], mean_q}) - xw)
			          : 48'(xw - {mean_q[47], mean_q});
			rem_q <= '0;
			dvs_q <= count_inc[31:0];
		end
		if (cmd.delta) begin
			quo_q <= {16'd0, (((xw - {mean_q[47], mean_q}) >> 48) != 49'd0)
			          ? 48'({mean_q[47], mean_q} - xw)
			          : 48'(xw - {mean_q[47], mean_q})};
		end else if (cmd.vsetup) begin
			quo_q <= sum_q;
			rem_q <= '0;
			dvs_q <= count_q - 32'd1;
		end else if (div_busy_q && div_cnt_q != 7'd0) begin
			if (!rem_sub[33]) begin
				rem_q <= rem_sub[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[32:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.mean) begin
			mplr_q <= d2[48] ? 48'(-d2) : d2[47:0];
			prod_q <= '0;
		end else if (cmd.mul_step && mul_cnt_q != 4'd12) begin
			prod_q <= prod_q + ({48'd0, pp} << {mul_cnt_q, 2'b00});
			mplr_q <= mplr_q >> 4;
		end
		if (cmd.vsetup) var_q <= '0;
		if (cmd.sqrt_start) begin
			var_q <= quo_q[63:16];
			rad_q <= {quo_q[63:16], 16'd0};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step && sq_cnt_q != 6'd0) begin
			rad_q <= rad_q << 2;
			if (srem_sh >= trial) begin
				srem_q <= srem_sh - trial;
				root_q <= {root_q[32:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[32:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			res.sample_count <= count_q;
			res.running_mean <= mean_q[47:16];
			res.sample_variance <= var_q;
			res.std_deviation <= sts.cnt_big ? root_q[31:0] : 32'd0;
			res.sample_ignored <= ign_q;
		end
	end

endmodule

### design/running_mean_variance.sv
// Channel  | Direction | Payload
// in       | input     | rmv_in_t  (command, sample)
// out      | output    | rmv_out_t (count, mean, variance, std deviation, ignored flag)
// A push runs through the delta step, the first division, the mean update, the product,
// the accumulation and the variance setup, then the second division and the square root
// when the count exceeds one. A clear and an ignored sample take the variance path only.
// Reset clears all statistics; one item is in work at a time.
// The result register holds its request while out_ready is low; in_ready waits for it.
module running_mean_variance
	import rmv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rmv_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rmv_out_t out_data
);

	rmv_cmd_t cmd;
	rmv_sts_t sts;
	logic     busy;
	logic     sat;
	logic     in_fire;
	logic     out_free;
	logic     out_valid_q;

	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	rmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_clear (in_data.command == CMD_CLEAR),
		.in_sat   (sat),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	rmv_dp u_dp (
		.clk     (clk),
		.in_item (in_data),
		.cmd     (cmd),
		.arst_n  (arst_n),
		.sts     (sts),
		.sat     (sat),
		.res     (out_data)
	);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("accepted while busy");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free) else $error("result overwritten");
	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid) else $error("result lost");
`endif

endmodule
